[hw/rtl/tpg_pkg.sv]
// ----------------------------------------------------------------------------
// Torus point generator package
// Shared types, widths and constants for the torus point generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned StepWidth = 16;
  localparam int unsigned RadiusWidth = 14;
  localparam int unsigned CenterWidth = 16;

  // CORDIC datapath: Q2.30 values and 32-bit turn fractions, with guard bits.
  localparam int unsigned CordicWidth = 34;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TrigWidth = 17;

  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

  localparam logic signed [CordicWidth-1:0] AtanTurn32 [CordicSteps] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
    34'sd2670163,   34'sd1335086,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41721,     34'sd20860
  };

  typedef enum logic [CfgIdxWidth-1:0] {
    RegAngleStep = 2'd0,
    RegRadius    = 2'd1,
    RegCenterX   = 2'd2,
    RegCenterY   = 2'd3
  } tpg_reg_e;

  // One rotation lane travelling through the cell chain.
  typedef struct packed {
    logic signed [CordicWidth-1:0] x;
    logic signed [CordicWidth-1:0] y;
    logic signed [CordicWidth-1:0] z;
    logic                          neg;
  } tpg_lane_t;

  // Configuration values seen by the arithmetic back end.
  typedef struct packed {
    logic [RadiusWidth-1:0]        radius;
    logic signed [CenterWidth-1:0] origin_x;
    logic signed [CenterWidth-1:0] origin_y;
  } tpg_geom_t;

endpackage

[hw/rtl/tpg_if.sv]
// ----------------------------------------------------------------------------
// Torus point generator stream interfaces
// Valid/ready channels for index pairs in and points out.
// ----------------------------------------------------------------------------
interface tpg_in_if #(
  parameter int unsigned IndexWidth = 10
);
  logic                  valid;
  logic                  ready;
  logic [IndexWidth-1:0] ring_index;
  logic [IndexWidth-1:0] tube_index;

  modport source (output valid, ring_index, tube_index, input ready);
  modport sink (input valid, ring_index, tube_index, output ready);
endinterface

interface tpg_out_if #(
  parameter int unsigned CoordWidth = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] point_x;
  logic signed [CoordWidth-1:0] point_y;
  logic signed [CoordWidth-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

[hw/rtl/tpg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step for both angle lanes, registered toward the next cell.
// ----------------------------------------------------------------------------
module tpg_cordic_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tpg_pkg::tpg_lane_t a_i,
  input  tpg_pkg::tpg_lane_t b_i,
  output logic              valid_o,
  output tpg_pkg::tpg_lane_t a_o,
  output tpg_pkg::tpg_lane_t b_o
);

  localparam logic signed [tpg_pkg::CordicWidth-1:0] Atan = tpg_pkg::AtanTurn32[Shift];

  function automatic tpg_pkg::tpg_lane_t rotate(input tpg_pkg::tpg_lane_t l);
    tpg_pkg::tpg_lane_t r;
    r = l;
    if (!l.z[tpg_pkg::CordicWidth-1]) begin
      r.x = l.x - (l.y >>> Shift);
      r.y = l.y + (l.x >>> Shift);
      r.z = l.z - Atan;
    end else begin
      r.x = l.x + (l.y >>> Shift);
      r.y = l.y - (l.x >>> Shift);
      r.z = l.z + Atan;
    end
    return r;
  endfunction

  tpg_pkg::tpg_lane_t a_d, b_d, a_q, b_q;
  logic valid_q;

  assign a_d = rotate(a_i);
  assign b_d = rotate(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign valid_o = valid_q;
  assign a_o = a_q;
  assign b_o = b_q;

endmodule

[hw/rtl/tpg_combine.sv]
// ----------------------------------------------------------------------------
// Torus point combiner
// Rounds sine and cosine, forms the coordinate products and saturates.
// ----------------------------------------------------------------------------
module tpg_combine #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  tpg_pkg::tpg_lane_t           a_i,
  input  tpg_pkg::tpg_lane_t           b_i,
  input  tpg_pkg::tpg_geom_t           geom_i,
  output logic                         valid_o,
  output logic signed [CoordWidth-1:0] point_x_o,
  output logic signed [CoordWidth-1:0] point_y_o,
  output logic signed [CoordWidth-1:0] point_z_o
);

  localparam int unsigned CW = tpg_pkg::CordicWidth;
  localparam int unsigned TW = tpg_pkg::TrigWidth;
  localparam int unsigned RW = tpg_pkg::RadiusWidth + 1;
  localparam int unsigned PW = 2 * TW;
  localparam int unsigned RPW = RW + PW;
  localparam int unsigned AccWidth = 52;
  localparam logic signed [AccWidth-1:0] SatHi =
    AccWidth'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
  localparam logic signed [AccWidth-1:0] SatLo = -(AccWidth'(64'sd1 <<< (CoordWidth - 1)));

  function automatic logic signed [TW-1:0] round_q15(input logic signed [CW-1:0] v,
                                                     input logic neg);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] s;
    t = neg ? -v : v;
    s = (t + CW'(34'sd16384)) >>> 15;
    return s[TW-1:0];
  endfunction

  function automatic logic signed [CoordWidth-1:0] sat(input logic signed [AccWidth-1:0] acc,
                                                       input int unsigned frac);
    logic signed [AccWidth-1:0] v;
    v = (acc + (AccWidth'(64'sd1) <<< (frac - 1))) >>> frac;
    if (v > SatHi) begin
      v = SatHi;
    end else if (v < SatLo) begin
      v = SatLo;
    end
    return v[CoordWidth-1:0];
  endfunction

  logic signed [RW-1:0] r_s;
  assign r_s = $signed({1'b0, geom_i.radius});

  // Stage R: rounded trig values.
  logic r_valid_q;
  logic signed [TW-1:0] sa_q, ca_q, sb_q, cb_q;
  // Stage M1: first products.
  logic m1_valid_q;
  logic signed [PW-1:0] sbca_q, sbsa_q, rsa_q, rca_q, rcb_q;
  // Stage M2: radius times the mixed products.
  logic m2_valid_q;
  logic signed [RPW-1:0] rsbca_q, rsbsa_q;
  logic signed [PW-1:0] rsa2_q, rca2_q, rcb2_q;
  // Output register.
  logic out_valid_q;
  logic signed [CoordWidth-1:0] px_q, py_q, pz_q;

  logic signed [AccWidth-1:0] ax, ay, az;

  always_comb begin
    ax = (AccWidth'(geom_i.origin_x) <<< 30) - (AccWidth'(rsa2_q) <<< 15)
       - AccWidth'(rsbca_q);
    ay = (AccWidth'(geom_i.origin_y) <<< 30) - (AccWidth'(rca2_q) <<< 15)
       - AccWidth'(rsbsa_q);
    az = AccWidth'(rcb2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      r_valid_q   <= valid_i;
      m1_valid_q  <= r_valid_q;
      m2_valid_q  <= m1_valid_q;
      out_valid_q <= m2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= round_q15(a_i.x, a_i.neg);
      sa_q <= round_q15(a_i.y, a_i.neg);
      cb_q <= round_q15(b_i.x, b_i.neg);
      sb_q <= round_q15(b_i.y, b_i.neg);

      sbca_q <= sb_q * ca_q;
      sbsa_q <= sb_q * sa_q;
      rsa_q  <= PW'(r_s * sa_q);
      rca_q  <= PW'(r_s * ca_q);
      rcb_q  <= PW'(r_s * cb_q);

      rsbca_q <= r_s * sbca_q;
      rsbsa_q <= r_s * sbsa_q;
      rsa2_q  <= rsa_q;
      rca2_q  <= rca_q;
      rcb2_q  <= rcb_q;

      px_q <= sat(ax, 30);
      py_q <= sat(ay, 30);
      pz_q <= sat(az, 15);
    end
  end

  assign valid_o = out_valid_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;

endmodule

[hw/rtl/torus_point_generator_core.sv]
// ----------------------------------------------------------------------------
// Torus point generator core
// Maps a (ring, tube) index pair to a point on a torus through a CORDIC chain.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// in_if     sink       ring_index, tube_index
// out_if    source     point_x, point_y, point_z (signed Q8.8, saturated)
// cfg       write      angle_step, radius, origin x, origin y
//
// One transaction is accepted per cycle unless the output stalls; the stages are
// angle product, quadrant fold, 16 CORDIC cells, rounding and two multiply stages, output.
// The whole pipeline advances together and halts only while a finished point
// waits at the output register and the sink is not ready.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module torus_point_generator_core #(
  parameter int unsigned CoordWidth = 16,
  parameter int unsigned AngleWidth = 16,
  parameter int unsigned IndexWidth = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tpg_in_if.sink                              in_if,
  tpg_out_if.source                           out_if,
  input  logic                                cfg_we_i,
  input  logic [tpg_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [tpg_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  localparam int unsigned CW = tpg_pkg::CordicWidth;
  localparam int unsigned ProdWidth = IndexWidth + tpg_pkg::StepWidth + AngleWidth;

  logic [tpg_pkg::StepWidth-1:0]   step_q;
  tpg_pkg::tpg_geom_t              geom_q;
  logic                            en;

  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q          <= tpg_pkg::StepWidth'(1024);
      geom_q.radius   <= tpg_pkg::RadiusWidth'(256);
      geom_q.origin_x <= '0;
      geom_q.origin_y <= '0;
    end else if (cfg_we_i) begin
      case (tpg_pkg::tpg_reg_e'(cfg_index_i))
        tpg_pkg::RegAngleStep: step_q <= cfg_data_i;
        tpg_pkg::RegRadius:    geom_q.radius <= cfg_data_i[tpg_pkg::RadiusWidth-1:0];
        tpg_pkg::RegCenterX:   geom_q.origin_x <= $signed(cfg_data_i);
        tpg_pkg::RegCenterY:   geom_q.origin_y <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Stage 0: turn fractions, wrapped to one full turn.
  logic                  s0_valid_q;
  logic [AngleWidth-1:0] ang_a_q, ang_b_q;
  logic [ProdWidth-1:0]  prod_a, prod_b;

  assign prod_a = ProdWidth'(in_if.ring_index) * ProdWidth'(step_q);
  assign prod_b = ProdWidth'(in_if.tube_index) * ProdWidth'(step_q);

  // Stage 1: fold the second and third quadrants by a half turn.
  function automatic tpg_pkg::tpg_lane_t fold(input logic [AngleWidth-1:0] ang);
    tpg_pkg::tpg_lane_t l;
    logic [31:0] a32;
    a32 = {ang, (32 - AngleWidth)'(0)};
    l.neg = a32[31] ^ a32[30];
    if (l.neg) begin
      a32[31] = ~a32[31];
    end
    l.x = tpg_pkg::CordicGain;
    l.y = '0;
    l.z = CW'($signed(a32));
    return l;
  endfunction

  logic               s1_valid_q;
  tpg_pkg::tpg_lane_t s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_if.valid;
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_a_q <= prod_a[AngleWidth-1:0];
      ang_b_q <= prod_b[AngleWidth-1:0];
      s1_a_q  <= fold(ang_a_q);
      s1_b_q  <= fold(ang_b_q);
    end
  end

  logic               chain_valid [tpg_pkg::CordicSteps+1];
  tpg_pkg::tpg_lane_t chain_a     [tpg_pkg::CordicSteps+1];
  tpg_pkg::tpg_lane_t chain_b     [tpg_pkg::CordicSteps+1];

  assign chain_valid[0] = s1_valid_q;
  assign chain_a[0] = s1_a_q;
  assign chain_b[0] = s1_b_q;

  for (genvar k = 0; k < tpg_pkg::CordicSteps; k++) begin : g_cell
    tpg_cordic_cell #(
      .Shift(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(chain_valid[k]),
      .a_i    (chain_a[k]),
      .b_i    (chain_b[k]),
      .valid_o(chain_valid[k+1]),
      .a_o    (chain_a[k+1]),
      .b_o    (chain_b[k+1])
    );
  end

  tpg_combine #(
    .CoordWidth(CoordWidth)
  ) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (chain_valid[tpg_pkg::CordicSteps]),
    .a_i      (chain_a[tpg_pkg::CordicSteps]),
    .b_i      (chain_b[tpg_pkg::CordicSteps]),
    .geom_i   (geom_q),
    .valid_o  (out_if.valid),
    .point_x_o(out_if.point_x),
    .point_y_o(out_if.point_y),
    .point_z_o(out_if.point_z)
  );

endmodule

[hw/rtl/tpg_checker.sv]
// ----------------------------------------------------------------------------
// Torus point generator checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module tpg_checker #(
  parameter int unsigned CoordWidth = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [CoordWidth-1:0] point_x_i,
  input logic [CoordWidth-1:0] point_y_i,
  input logic [CoordWidth-1:0] point_z_i
);

  // The input side is only held back by a stalled output transaction.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow the output stall");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(point_x_i) && $stable(point_y_i) && $stable(point_z_i))
    else $error("output payload changed while stalled");

endmodule

bind torus_point_generator_core tpg_checker #(
  .CoordWidth(CoordWidth)
) u_tpg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .point_x_i  (out_if.point_x),
  .point_y_i  (out_if.point_y),
  .point_z_i  (out_if.point_z)
);

[bench/torus_point_checker.sv]
// ----------------------------------------------------------------------------
// Torus point checker
// Watches the index and point channels, predicts each point from the index
// pair and the current geometry, and compares it with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module torus_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpg_in_if           in_if,
  tpg_out_if          out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  localparam longint AtanTab [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10680862,
    5340245, 2670163, 1335086, 667544, 333772, 166886, 83443, 41721, 20860
  };

  logic [15:0]        step_q;
  logic [13:0]        radius_q;
  logic signed [15:0] cx_q;
  logic signed [15:0] cy_q;
  point_t             expected_points[$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_points.size();

  // Arithmetic shift on a signed value floors, as the datapath does.
  function automatic longint floor_div(longint v, int k);
    return v >>> k;
  endfunction

  task automatic rotate(input logic [15:0] angle, output longint s, output longint c);
    logic [31:0] a32;
    logic        flip;
    longint      px, py, pz, nx;
    a32  = {angle, 16'h0};
    flip = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
    if (flip) a32 = a32 - 32'h8000_0000;
    pz = longint'(signed'(a32));
    px = 652032874;
    py = 0;
    for (int k = 0; k < 16; k++) begin
      if (pz >= 0) begin
        nx = px - floor_div(py, k);
        py = py + floor_div(px, k);
        pz -= AtanTab[k];
      end else begin
        nx = px + floor_div(py, k);
        py = py - floor_div(px, k);
        pz += AtanTab[k];
      end
      px = nx;
    end
    if (flip) begin
      px = -px;
      py = -py;
    end
    c = floor_div(px + (64'sd1 <<< 14), 15);
    s = floor_div(py + (64'sd1 <<< 14), 15);
  endtask

  function automatic logic signed [15:0] round_sat(longint acc, int sh);
    longint v;
    v = floor_div(acc + (64'sd1 <<< (sh - 1)), sh);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_point(input logic [9:0] ring, input logic [9:0] tube);
    longint sa, ca, sb, cb, r;
    logic [15:0] a, b;
    point_t p;
    a = 16'(ring * step_q);
    b = 16'(tube * step_q);
    rotate(a, sa, ca);
    rotate(b, sb, cb);
    r = radius_q;
    p.x = round_sat(longint'(cx_q) * (64'sd1 <<< 30) - r * sa * 32768 - r * (sb * ca), 30);
    p.y = round_sat(longint'(cy_q) * (64'sd1 <<< 30) - r * ca * 32768 - r * (sb * sa), 30);
    p.z = round_sat(r * cb, 15);
    expected_points.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      step_q   <= 16'd1024;
      radius_q <= 14'd256;
      cx_q     <= '0;
      cy_q     <= '0;
      fails    = 0;
      expected_points.delete();
    end else begin
      if (in_if.valid && in_if.ready) predict_point(in_if.ring_index, in_if.tube_index);
      if (out_if.valid && out_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("point with no transaction pending");
          fails++;
        end else begin
          e = expected_points.pop_front();
          if (out_if.point_x !== e.x) begin
            $error("point_x expected %0d got %0d", e.x, out_if.point_x);
            fails++;
          end
          if (out_if.point_y !== e.y) begin
            $error("point_y expected %0d got %0d", e.y, out_if.point_y);
            fails++;
          end
          if (out_if.point_z !== e.z) begin
            $error("point_z expected %0d got %0d", e.z, out_if.point_z);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (tpg_pkg::tpg_reg_e'(cfg_index_i))
          tpg_pkg::RegAngleStep: step_q <= cfg_data_i;
          tpg_pkg::RegRadius:    radius_q <= cfg_data_i[13:0];
          tpg_pkg::RegCenterX:   cx_q <= cfg_data_i;
          tpg_pkg::RegCenterY:   cy_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[bench/torus_point_generator_core_test.sv]
// ----------------------------------------------------------------------------
// Torus point generator core test
// Drives index pairs with random gaps and output stalls over several
// geometry settings; the checker predicts and compares every point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module torus_point_generator_core_test;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  int          fail_count;
  int          pending;
  int          sent;

  tpg_in_if  #(.IndexWidth(10)) in_if ();
  tpg_out_if #(.CoordWidth(16)) out_if ();

  torus_point_generator_core dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  torus_point_checker checker_u (
    .clk_i, .rst_ni, .in_if, .out_if, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output stalls; a third of the time the sink stays ready throughout.
  logic stall_on;
  initial begin
    out_if.ready = 1'b0;
    stall_on = 1'b1;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 299) == 0) stall_on = ($urandom_range(0, 2) != 0);
      if (stall_on && $urandom_range(0, 40) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(8, 40)) @(negedge clk_i);
      end else begin
        out_if.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  task automatic write_reg(input tpg_pkg::tpg_reg_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pair(input logic [9:0] ring, input logic [9:0] tube);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.ring_index <= ring;
    in_if.tube_index <= tube;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Lets the pipeline run empty before the geometry changes.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [15:0] st, input logic [13:0] r,
                              input logic [15:0] x, input logic [15:0] y);
    drain();
    write_reg(tpg_pkg::RegAngleStep, st);
    write_reg(tpg_pkg::RegRadius, {2'b0, r});
    write_reg(tpg_pkg::RegCenterX, x);
    write_reg(tpg_pkg::RegCenterY, y);
  endtask

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      send_pair(10'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.ring_index = '0;
    in_if.tube_index = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset geometry: quadrant points, index extremes.
    send_pair(0, 0);
    send_pair(16, 16);
    send_pair(32, 48);
    send_pair(48, 32);
    send_pair(1023, 1023);
    send_pair(1023, 0);
    send_pair(0, 1023);
    send_pair(10'h2AA, 10'h155);
    // Zero step puts every point at angle zero.
    set_geometry(16'd0, 14'd300, 16'h0100, 16'hFF00);
    send_pair(5, 700);
    send_pair(1023, 1);
    // Largest radius and centers at the extremes drive saturation.
    set_geometry(16'hFFFF, 14'h3FFF, 16'h7FFF, 16'h8000);
    send_pair(1, 1);
    send_pair(1023, 512);
    send_pair(256, 768);
    set_geometry(16'h4000, 14'h3FFF, 16'h8000, 16'h7FFF);
    send_pair(1, 2);
    send_pair(3, 1);
    send_pair(2, 3);
    set_geometry(16'h8000, 14'd0, 16'h0000, 16'h0000);
    send_pair(1, 1);
    send_pair(10'h3FF, 10'h3FE);

    set_geometry(16'd1024, 14'd256, 16'd0, 16'd0);
    random_phase(200);
    for (int p = 0; p < 6; p++) begin
      set_geometry(16'($urandom), 14'($urandom), 16'($urandom), 16'($urandom));
      random_phase(150);
    end
    set_geometry(16'd1, 14'h3FFF, 16'h7FFF, 16'h8000);
    random_phase(30);
    drain();

    $display("Sent %0d index pairs over twelve geometry settings,", sent);
    $display("including zero step, zero radius and saturating extremes.");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
